[rtl/core/chgs_pkg.sv]
// Package for the Graham-scan hull core: port structs, run command, FSM states.
// No dependencies.
package chgs_pkg;

	localparam int COORD_W = 16;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = 7;
	localparam int PT_W    = 2 * COORD_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      set_end;
	} point_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] hull_x;
		logic signed [COORD_W-1:0] hull_y;
		logic                      hull_end;
		logic                      dropped_points;
	} hull_out_t;

	// one loaded set, handed from the loader to the hull engine
	typedef struct packed {
		logic [CNT_W-1:0]          count;
		logic [IDX_W-1:0]          pivot;
		logic signed [COORD_W-1:0] piv_x;
		logic signed [COORD_W-1:0] piv_y;
		logic                      overflow;
	} run_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_NEXT, ST_LDA, ST_CHK, ST_RDO, ST_RDB, ST_M1, ST_M2, ST_DEC,
		SC_INIT, SC_RDO, SC_RDP, SC_LDC, SC_TST, SC_POP, EM_RD, EM_OUT
	} back_state_t;

	function automatic logic signed [COORD_W:0] sx(input logic signed [COORD_W-1:0] v);
		return {v[COORD_W-1], v};
	endfunction

	function automatic logic [COORD_W:0] mag(input logic signed [COORD_W:0] v);
		return v[COORD_W] ? $unsigned(-v) : $unsigned(v);
	endfunction

endpackage

[rtl/core/convex_hull_graham_scan_core.sv]
// channel | ports                         | handshake
// in      | point (point_in_t)            | start & !busy
// out     | hull (hull_out_t), hull_valid | strobe, one cycle, no backpressure
// Points load one per cycle while busy is low. After the set_end point the engine sorts
// by insertion (order N^2 compares), scans (a turn test per stack check, and a stack
// read on a pop that reloads the second entry), then emits the vertices from the stack RAM.
// busy is high from the set_end point until the last vertex leaves. Reset clears control.
module convex_hull_graham_scan_core #(
	parameter int MAX_POINTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  chgs_pkg::point_in_t point,
	output logic                hull_valid,
	output chgs_pkg::hull_out_t hull
);
	import chgs_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);

	logic            accept, push, pop, q_valid, eng_active;
	logic            pt_we;
	logic [IW-1:0]   pt_waddr, pt_raddr;
	logic [PT_W-1:0] pt_wdata, pt_rdata;
	run_cmd_t        cmd_in, cmd_head;

	assign accept = start && !busy;
	assign busy   = q_valid || eng_active;

	chgs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .point(point),
		.pt_we(pt_we), .pt_waddr(pt_waddr), .pt_wdata(pt_wdata),
		.push(push), .cmd(cmd_in)
	);

	chgs_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_points (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);

	chgs_cmd_fifo u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(cmd_in),
		.pop(pop), .not_empty(q_valid), .head(cmd_head)
	);

	chgs_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(q_valid), .cmd(cmd_head),
		.pop(pop), .active(eng_active), .pt_raddr(pt_raddr), .pt_rdata(pt_rdata),
		.hull_valid(hull_valid), .hull(hull)
	);
endmodule

[rtl/core/chgs_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module chgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/chgs_front.sv]
// Loader: stores points, tracks count, overflow and pivot, issues a run command.
// Depends on chgs_pkg.
module chgs_front #(
	parameter int MAX_POINTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  chgs_pkg::point_in_t           point,
	output logic                          pt_we,
	output logic [$clog2(MAX_POINTS)-1:0] pt_waddr,
	output logic [chgs_pkg::PT_W-1:0]     pt_wdata,
	output logic                          push,
	output chgs_pkg::run_cmd_t            cmd
);
	import chgs_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [CW-1:0]              cnt_q;
	logic                       ovf_q;
	logic [IW-1:0]              piv_q;
	logic signed [COORD_W-1:0]  px_q, py_q;
	logic                       room, new_piv;

	assign room    = cnt_q < CW'(MAX_POINTS);
	assign new_piv = room && (cnt_q == '0 || point.point_y < py_q ||
		(point.point_y == py_q && point.point_x < px_q));

	assign pt_we    = accept && room;
	assign pt_waddr = cnt_q[IW-1:0];
	assign pt_wdata = {point.point_x, point.point_y};
	assign push     = accept && point.set_end;

	always_comb begin
		cmd.count    = CNT_W'(cnt_q) + CNT_W'(room);
		cmd.pivot    = IDX_W'(new_piv ? cnt_q[IW-1:0] : piv_q);
		cmd.piv_x    = new_piv ? point.point_x : px_q;
		cmd.piv_y    = new_piv ? point.point_y : py_q;
		cmd.overflow = ovf_q || !room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (point.set_end) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (room) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && new_piv) begin
			piv_q <= cnt_q[IW-1:0];
			px_q  <= point.point_x;
			py_q  <= point.point_y;
		end
	end
endmodule

[rtl/core/chgs_cmd_fifo.sv]
// Two-entry queue of run commands between loader and hull engine.
// Depends on chgs_pkg.
module chgs_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  chgs_pkg::run_cmd_t din,
	input  logic               pop,
	output logic               not_empty,
	output chgs_pkg::run_cmd_t head
);
	import chgs_pkg::*;

	run_cmd_t   ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign not_empty = cnt_q != 2'd0;
	assign head      = ent_q[rp_q];
	assign do_push   = push && cnt_q != 2'd2;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= din;
		end
	end
endmodule

[rtl/core/chgs_back.sv]
// Hull engine: insertion sort by angle, stack scan, then vertex output.
// Depends on chgs_pkg and chgs_ram.
module chgs_back #(
	parameter int MAX_POINTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  chgs_pkg::run_cmd_t            cmd,
	output logic                          pop,
	output logic                          active,
	output logic [$clog2(MAX_POINTS)-1:0] pt_raddr,
	input  logic [chgs_pkg::PT_W-1:0]     pt_rdata,
	output logic                          hull_valid,
	output chgs_pkg::hull_out_t           hull
);
	import chgs_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int DW = COORD_W + 1;

	back_state_t state_q, state_d;

	logic [CW-1:0] n_q, i_q, j_q, k_q, dep_q, e_q;
	logic [IW-1:0] piv_q, b_q;
	logic          ovf_q, scan_q;
	logic [PT_W-1:0] piv_pt_q, a_q, c_q, s1_q, s2_q;
	logic signed [DW-1:0]   ux_q, uy_q, vx_q, vy_q;
	logic [DW:0]            la_q, lb_q;
	logic signed [2*DW-1:0] p_q, q_q;

	logic          ord_we, st_we;
	logic [IW-1:0] ord_waddr, ord_raddr, ord_rdata, ord_wdata;
	logic [IW-1:0] st_waddr, st_raddr;
	logic [PT_W-1:0] st_rdata;
	logic          before_w, pop_w, dup_w;

	chgs_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_order (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	chgs_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_stack (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(c_q),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	// collinear with the pivot means same ray, so L1 length orders like distance
	assign before_w = (p_q == q_q) ? (la_q < lb_q) : (p_q < q_q);
	assign pop_w    = p_q >= q_q;
	assign dup_w    = dep_q != '0 && s1_q == c_q;
	assign active   = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd_valid) state_d = ST_NEXT;
			ST_NEXT: begin
				if (i_q == n_q) state_d = SC_INIT;
				else if (i_q[IW-1:0] != piv_q) state_d = ST_LDA;
			end
			ST_LDA:  state_d = ST_CHK;
			ST_CHK:  state_d = (j_q > CW'(1)) ? ST_RDO : ST_NEXT;
			ST_RDO:  state_d = ST_RDB;
			ST_RDB:  state_d = ST_M1;
			ST_M1:   state_d = ST_M2;
			ST_M2:   state_d = ST_DEC;
			ST_DEC: begin
				if (scan_q) state_d = (pop_w && dep_q >= CW'(3)) ? SC_POP :
					(pop_w ? SC_TST : SC_RDO);
				else state_d = before_w ? ST_CHK : ST_NEXT;
			end
			SC_INIT: state_d = SC_RDO;
			SC_RDO:  state_d = (i_q == n_q) ? EM_RD : SC_RDP;
			SC_RDP:  state_d = SC_LDC;
			SC_LDC:  state_d = SC_TST;
			SC_TST: begin
				if (dup_w || dep_q <= CW'(1)) state_d = SC_RDO;
				else state_d = ST_M1;
			end
			SC_POP:  state_d = SC_TST;
			EM_RD:   state_d = (e_q == dep_q) ? ST_IDLE : EM_OUT;
			EM_OUT:  state_d = EM_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		pt_raddr   = i_q[IW-1:0];
		ord_we     = 1'b0;
		ord_waddr  = j_q[IW-1:0];
		ord_wdata  = i_q[IW-1:0];
		ord_raddr  = IW'(j_q - CW'(1));
		st_we      = 1'b0;
		st_waddr   = dep_q[IW-1:0];
		st_raddr   = IW'(dep_q - CW'(3));
		hull_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pop       = cmd_valid;
				ord_we    = cmd_valid;
				ord_waddr = '0;
				ord_wdata = cmd.pivot[IW-1:0];
			end
			ST_CHK:  ord_we = j_q <= CW'(1);
			ST_RDO:  pt_raddr = ord_rdata;
			ST_DEC: begin
				if (!scan_q) begin
					ord_we    = 1'b1;
					ord_wdata = before_w ? b_q : i_q[IW-1:0];
				end else begin
					st_we = !pop_w;
				end
			end
			SC_RDO:  ord_raddr = i_q[IW-1:0];
			SC_RDP:  pt_raddr = ord_rdata;
			SC_TST:  st_we = !dup_w && dep_q <= CW'(1);
			EM_RD:   st_raddr = e_q[IW-1:0];
			EM_OUT:  hull_valid = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		hull.hull_x         = st_rdata[PT_W-1:COORD_W];
		hull.hull_y         = st_rdata[COORD_W-1:0];
		hull.hull_end       = e_q == dep_q - CW'(1);
		hull.dropped_points = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (cmd_valid) begin
				n_q      <= cmd.count[CW-1:0];
				piv_q    <= cmd.pivot[IW-1:0];
				piv_pt_q <= {cmd.piv_x, cmd.piv_y};
				ovf_q    <= cmd.overflow;
				scan_q   <= 1'b0;
				i_q      <= '0;
				k_q      <= CW'(1);
			end
			ST_NEXT: if (i_q != n_q && i_q[IW-1:0] == piv_q) i_q <= i_q + CW'(1);
			ST_LDA: begin
				a_q <= pt_rdata;
				j_q <= k_q;
			end
			ST_CHK: if (j_q <= CW'(1)) begin
				k_q <= k_q + CW'(1);
				i_q <= i_q + CW'(1);
			end
			ST_RDO: b_q <= ord_rdata;
			ST_RDB: begin
				ux_q <= sx(a_q[PT_W-1:COORD_W]) - sx(piv_pt_q[PT_W-1:COORD_W]);
				uy_q <= sx(a_q[COORD_W-1:0]) - sx(piv_pt_q[COORD_W-1:0]);
				vx_q <= sx(pt_rdata[PT_W-1:COORD_W]) - sx(a_q[PT_W-1:COORD_W]);
				vy_q <= sx(pt_rdata[COORD_W-1:0]) - sx(a_q[COORD_W-1:0]);
				la_q <= {1'b0, mag(sx(a_q[PT_W-1:COORD_W]) - sx(piv_pt_q[PT_W-1:COORD_W]))}
					+ {1'b0, mag(sx(a_q[COORD_W-1:0]) - sx(piv_pt_q[COORD_W-1:0]))};
				lb_q <= {1'b0, mag(sx(pt_rdata[PT_W-1:COORD_W])
					- sx(piv_pt_q[PT_W-1:COORD_W]))}
					+ {1'b0, mag(sx(pt_rdata[COORD_W-1:0]) - sx(piv_pt_q[COORD_W-1:0]))};
			end
			ST_M1: p_q <= ux_q * vy_q;
			ST_M2: q_q <= uy_q * vx_q;
			ST_DEC: begin
				if (!scan_q) begin
					if (before_w) begin
						j_q <= j_q - CW'(1);
					end else begin
						k_q <= k_q + CW'(1);
						i_q <= i_q + CW'(1);
					end
				end else if (pop_w) begin
					dep_q <= dep_q - CW'(1);
					s1_q  <= s2_q;
				end else begin
					s2_q  <= s1_q;
					s1_q  <= c_q;
					dep_q <= dep_q + CW'(1);
					i_q   <= i_q + CW'(1);
				end
			end
			SC_INIT: begin
				scan_q <= 1'b1;
				i_q    <= '0;
				dep_q  <= '0;
				e_q    <= '0;
			end
			SC_LDC: c_q <= pt_rdata;
			SC_TST: begin
				if (dup_w) begin
					i_q <= i_q + CW'(1);
				end else if (dep_q <= CW'(1)) begin
					s2_q  <= s1_q;
					s1_q  <= c_q;
					dep_q <= dep_q + CW'(1);
					i_q   <= i_q + CW'(1);
				end else begin
					ux_q <= sx(s1_q[PT_W-1:COORD_W]) - sx(s2_q[PT_W-1:COORD_W]);
					uy_q <= sx(s1_q[COORD_W-1:0]) - sx(s2_q[COORD_W-1:0]);
					vx_q <= sx(c_q[PT_W-1:COORD_W]) - sx(s1_q[PT_W-1:COORD_W]);
					vy_q <= sx(c_q[COORD_W-1:0]) - sx(s1_q[COORD_W-1:0]);
				end
			end
			SC_POP: s2_q <= st_rdata;
			EM_OUT: e_q <= e_q + CW'(1);
			default: ;
		endcase
	end
endmodule

[dv/hull_checker.sv]
// Checker for the Graham-scan hull core: predicts hull vertices per point set and
// compares every strobed word. Depends on chgs_pkg.
module hull_checker #(
	parameter int MAX_POINTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  chgs_pkg::point_in_t point,
	input  logic                hull_valid,
	input  chgs_pkg::hull_out_t hull,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import chgs_pkg::*;

	logic signed [COORD_W-1:0] xs [MAX_POINTS];
	logic signed [COORD_W-1:0] ys [MAX_POINTS];
	int loaded;
	bit overflow;
	hull_out_t hull_q[$];

	function automatic int orient(int a, int b, int c);
		longint ux, uy, vx, vy, p, q;
		ux = xs[b] - xs[a]; uy = ys[b] - ys[a];
		vx = xs[c] - xs[b]; vy = ys[c] - ys[b];
		p = ux * vy; q = uy * vx;
		return (p > q) ? 1 : (p < q) ? -1 : 0;
	endfunction

	function automatic longint dist2(int p, int a);
		longint dx, dy;
		dx = xs[a] - xs[p]; dy = ys[a] - ys[p];
		return dx * dx + dy * dy;
	endfunction

	function automatic bit sorts_first(int p, int a, int b);
		int o;
		o = orient(p, a, b);
		if (o == 0) return dist2(p, a) < dist2(p, b);
		return o < 0;
	endfunction

	task automatic predict_hull();
		int order [MAX_POINTS];
		int stk [MAX_POINTS];
		int piv, k, j, depth, c;
		hull_out_t w;
		piv = 0;
		for (int i = 1; i < loaded; i++)
			if (ys[i] < ys[piv] || (ys[i] == ys[piv] && xs[i] < xs[piv])) piv = i;
		order[0] = piv;
		k = 1;
		for (int i = 0; i < loaded; i++) begin
			if (i == piv) continue;
			j = k;
			while (j > 1 && sorts_first(piv, i, order[j-1])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
			k++;
		end
		depth = 0;
		for (int i = 0; i < loaded; i++) begin
			c = order[i];
			if (depth > 0 && xs[stk[depth-1]] == xs[c] && ys[stk[depth-1]] == ys[c])
				continue;
			while (depth > 1 && orient(stk[depth-2], stk[depth-1], c) >= 0) depth--;
			if (depth < MAX_POINTS) stk[depth++] = c;
		end
		for (int i = 0; i < depth; i++) begin
			w.hull_x = xs[stk[i]];
			w.hull_y = ys[stk[i]];
			w.hull_end = (i + 1 == depth);
			w.dropped_points = overflow;
			hull_q = {hull_q, w};
		end
		loaded = 0;
		overflow = 0;
	endtask

	task automatic report(string what, hull_out_t got, hull_out_t exp_w);
		$display("%0t mismatch %s: got x=%0d y=%0d end=%0b drop=%0b exp x=%0d y=%0d end=%0b drop=%0b",
			$realtime, what, got.hull_x, got.hull_y, got.hull_end, got.dropped_points,
			exp_w.hull_x, exp_w.hull_y, exp_w.hull_end, exp_w.dropped_points);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		loaded = 0;
		overflow = 0;
	end

	always @(posedge clk) begin
		hull_out_t exp_w;
		if (arst_n) begin
			// vertex words first: a new set cannot start while one is being emitted
			if (hull_valid) begin
				if (hull_q.size() == 0) begin
					report("unexpected word", hull, '0);
				end else begin
					exp_w = hull_q.pop_front();
					if (hull.hull_x !== exp_w.hull_x) report("hull_x", hull, exp_w);
					if (hull.hull_y !== exp_w.hull_y) report("hull_y", hull, exp_w);
					if (hull.hull_end !== exp_w.hull_end) report("hull_end", hull, exp_w);
					if (hull.dropped_points !== exp_w.dropped_points)
						report("dropped_points", hull, exp_w);
				end
			end
			if (start && !busy) begin
				if (loaded < MAX_POINTS) begin
					xs[loaded] = point.point_x;
					ys[loaded] = point.point_y;
					loaded++;
				end else begin
					overflow = 1;
				end
				if (point.set_end) predict_hull();
			end
			pending = hull_q.size();
		end
	end
endmodule

[dv/tb_convex_hull_graham_scan_core.sv]
// Testbench top for the Graham-scan hull core: drives point sets with random gaps.
// Depends on chgs_pkg, convex_hull_graham_scan_core and hull_checker.
module tb_convex_hull_graham_scan_core;
	timeunit 1ns;
	timeprecision 1ps;
	import chgs_pkg::*;

	localparam int MAXP = 64;

	logic clk, arst_n, start, busy, hull_valid;
	point_in_t point;
	hull_out_t hull;
	int fail_count, pending;
	int sent;

	convex_hull_graham_scan_core #(.MAX_POINTS(MAXP)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point(point), .hull_valid(hull_valid), .hull(hull)
	);

	hull_checker #(.MAX_POINTS(MAXP)) u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.hull_valid(hull_valid), .hull(hull), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	// start stays high across a zero gap; within this task it drops only for a nonzero gap
	task automatic send_word(logic signed [15:0] x, logic signed [15:0] y, logic last);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		point <= '{point_x: x, point_y: y, set_end: last};
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// one set; mode picks the coordinate flavor
	task automatic send_set(int n, int mode);
		logic signed [15:0] x, y;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 3);
			case (mode)
				0: begin x = 16'($urandom); y = 16'($urandom); end
				1: begin
					x = 16'(int'($urandom_range(0, 8)) - 4);
					y = 16'(int'($urandom_range(0, 8)) - 4);
				end
				2: begin x = 16'(i * 3 - 30); y = 16'(i * 2 - 20); end
				default: begin
					x = r[0] ? 16'sh7fff : 16'sh8000;
					y = r[1] ? 16'sh7fff : 16'sh8000;
				end
			endcase
			send_word(x, y, i == n - 1);
		end
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 0;
		@(posedge clk);
		while ((pending != 0 || busy) && guard < 200_000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	initial begin
		start = 0;
		point = '0;
		sent = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: single point, duplicates, collinear, extremes, square with center
		send_word(16'sd5, -16'sd7, 1'b1);
		send_word(16'sd1, 16'sd1, 1'b0); send_word(16'sd1, 16'sd1, 1'b0);
		send_word(16'sd1, 16'sd1, 1'b1);
		send_set(5, 2);
		send_set(4, 3);
		send_word(16'sd0, 16'sd0, 1'b0); send_word(16'sd10, 16'sd0, 1'b0);
		send_word(16'sd5, 16'sd5, 1'b0); send_word(16'sd10, 16'sd10, 1'b0);
		send_word(16'sd0, 16'sd10, 1'b0); send_word(16'sd5, 16'sd0, 1'b1);
		drain();
		// overflow: capacity plus a few extra points
		send_set(MAXP + 3, 1);
		drain();
		send_set(MAXP, 0);
		while (sent < 420) begin
			case ($urandom_range(0, 3))
				0: send_set($urandom_range(1, 6), 1);
				1: send_set($urandom_range(2, 16), 0);
				2: send_set($urandom_range(1, 8), 3);
				default: send_set($urandom_range(3, 20), 1);
			endcase
			if ($urandom_range(0, 15) == 0) drain();
		end
		drain();
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
